/* rtl/core/tfnf_pkg.sv */
// Shared constants, types and face helpers for the tetra face neighbor finder.
package tfnf_pkg;

  localparam int MaxTets    = 1024;
  localparam int VertexBits = 20;
  localparam int TetW       = $clog2(MaxTets);
  localparam int CntW       = $clog2(MaxTets + 1);
  localparam int FaceW      = TetW + 2;
  localparam int FaceSlots  = 4 * MaxTets;
  localparam int FaceCntW   = FaceW + 1;
  localparam int KeyW       = 3 * VertexBits;
  localparam int EntW       = KeyW + FaceW;
  localparam int NbrW       = TetW + 1;

  // Port field widths
  localparam int VertInW = 20;
  localparam int IdxInW  = 10;

  // Result status codes
  localparam logic [1:0] StatBuildDone = 2'd0;
  localparam logic [1:0] StatReadOk    = 2'd1;
  localparam logic [1:0] StatOverflow  = 2'd2;
  localparam logic [1:0] StatBadIndex  = 2'd3;

  // Request codes
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef logic [VertexBits-1:0] vert_t;
  typedef logic [EntW-1:0]       face_ent_t;

  // Neighbor table write request
  typedef struct packed {
    logic [3:0]      we;
    logic [TetW-1:0] row;
    logic [NbrW-1:0] data;
  } nbr_wr_t;

  // Corners of face j: face opposite vertex j
  localparam logic [1:0] CornerOfFace [12] = '{
    2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd0, 2'd3, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2
  };

  // Sorted key of face j of a tetrahedron
  function automatic logic [KeyW-1:0] face_key(input vert_t v [4], input logic [1:0] j);
    vert_t a;
    vert_t b;
    vert_t c;
    vert_t t;
    a = v[CornerOfFace[3*j]];
    b = v[CornerOfFace[3*j+1]];
    c = v[CornerOfFace[3*j+2]];
    if (a > b) begin
      t = a; a = b; b = t;
    end
    if (b > c) begin
      t = b; b = c; c = t;
    end
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return {a, b, c};
  endfunction

endpackage

/* rtl/core/tfnf_ram.sv */
// Generic simple dual-port RAM with registered read data.
module tfnf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/core/tfnf_nbr_table.sv */
// Neighbor table: four banks, one per face slot, read as one row per tetrahedron.
module tfnf_nbr_table import tfnf_pkg::*; (
  input  logic            clk_i,
  input  nbr_wr_t         wr_i,
  input  logic [TetW-1:0] rrow_i,
  output logic [TetW-1:0] nbr_o   [4],
  output logic [3:0]      bound_o
);

  logic [NbrW-1:0] bank [4][MaxTets];
  logic [NbrW-1:0] rd_q [4];

  // One write port and one read port per bank
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (wr_i.we[k]) begin
        bank[k][wr_i.row] <= wr_i.data;
      end
      rd_q[k] <= bank[k][rrow_i];
    end
  end

  // Top bit marks a boundary face; boundary reads as neighbor zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bound_o[k] = rd_q[k][NbrW-1];
      nbr_o[k]   = rd_q[k][NbrW-1] ? '0 : rd_q[k][TetW-1:0];
    end
  end

endmodule

/* rtl/core/tetra_face_neighbor_finder_top.sv */
// Top level: load sequencer, merge sort over two face banks, pair scan, reads.
// Load: each tetrahedron is written as four face writes to one face memory port.
// Build after the last load: ceil(log2(4*count)) merge passes, then a scan of the
// sorted faces; one item at a time. Read: the index is registered, the table row read,
// then the result registered. Reset clears count, flags, state and output valid; face
// and neighbor memories are not cleared (each load marks its row).
module tetra_face_neighbor_finder_top import tfnf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // vert_0, vert_1, vert_2, vert_3, tet_index, pad
  input  logic        s_axis_tuser_i,  // func
  input  logic        s_axis_tlast_i,  // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // tet_count, nbr_0..nbr_3, bound_0..bound_3, pad
  output logic [1:0]  m_axis_tuser_o   // status
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StLoad  = 4'd1;
  localparam logic [3:0] StBinit = 4'd2;
  localparam logic [3:0] StRun   = 4'd3;
  localparam logic [3:0] StFa    = 4'd4;
  localparam logic [3:0] StFa2   = 4'd5;
  localparam logic [3:0] StFb2   = 4'd6;
  localparam logic [3:0] StMrg   = 4'd7;
  localparam logic [3:0] StCap   = 4'd8;
  localparam logic [3:0] StScA   = 4'd9;
  localparam logic [3:0] StScB   = 4'd10;
  localparam logic [3:0] StScC   = 4'd11;
  localparam logic [3:0] StDone  = 4'd12;
  localparam logic [3:0] StRd    = 4'd13;
  localparam logic [3:0] StRd2   = 4'd14;

  logic [3:0] state_q, state_d;

  // Control registers
  logic [CntW-1:0]     count_q, count_d;
  logic                built_q, built_d, ovf_q, ovf_d, last_q, last_d, sel_q, sel_d;
  logic                took_a_q, took_a_d;
  logic [1:0]          j_q, j_d;
  logic [FaceCntW-1:0] n_q, n_d, width_q, width_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
  logic [FaceCntW-1:0] a_q, a_d, b_q, b_d, o_q, o_d, i_q, i_d;

  // Payload registers
  vert_t               vert_q [4];
  logic [TetW-1:0]     idx_q;
  face_ent_t           ha_q, ha_d, hb_q, hb_d, prev_q, prev_d, cur_q, cur_d;

  // Result register
  logic        m_valid_q, m_valid_d;
  logic [55:0] m_data_q, m_data_d;
  logic [1:0]  m_user_q, m_user_d;

  // Memory signals
  logic             x_we, y_we;
  logic [FaceW-1:0] x_waddr, y_waddr, rd_addr;
  face_ent_t        x_wdata, y_wdata, x_rd, y_rd, rdata;
  nbr_wr_t          nbr_wr;
  logic [TetW-1:0]  nbr_rd [4];
  logic [3:0]       bnd_rd;

  logic                accept, out_free, a_ok, b_ok, take_a, key_eq;
  logic [FaceCntW:0]   lo_w, lo_2w, lo_next;
  logic [CntW-1:0]     eff_cnt, rd_cnt;
  face_ent_t           sel_ent;

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  tfnf_ram #(.Width(EntW), .Depth(FaceSlots)) u_bank_x (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(rd_addr), .rdata_o(x_rd)
  );

  tfnf_ram #(.Width(EntW), .Depth(FaceSlots)) u_bank_y (
    .clk_i, .we_i(y_we), .waddr_i(y_waddr), .wdata_i(y_wdata),
    .raddr_i(rd_addr), .rdata_o(y_rd)
  );

  tfnf_nbr_table u_nbr (
    .clk_i, .wr_i(nbr_wr), .rrow_i(idx_q), .nbr_o(nbr_rd), .bound_o(bnd_rd)
  );

  // Source bank select and merge compare
  assign rdata   = sel_q ? y_rd : x_rd;
  assign a_ok    = a_q < mid_q;
  assign b_ok    = b_q < hi_q;
  assign take_a  = a_ok && (!b_ok || !(hb_q < ha_q));
  assign sel_ent = take_a ? ha_q : hb_q;
  assign lo_w    = {1'b0, lo_q} + {1'b0, width_q};
  assign lo_2w   = lo_w + {1'b0, width_q};
  assign lo_next = lo_2w;
  assign key_eq  = rdata[EntW-1:FaceW] == prev_q[EntW-1:FaceW];
  assign eff_cnt = built_q ? '0 : count_q;
  assign rd_cnt  = built_q ? count_q : '0;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    built_d   = built_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    sel_d     = sel_q;
    took_a_d  = took_a_q;
    j_d       = j_q;
    n_d       = n_q;
    width_d   = width_q;
    lo_d      = lo_q;
    mid_d     = mid_q;
    hi_d      = hi_q;
    a_d       = a_q;
    b_d       = b_q;
    o_d       = o_q;
    i_d       = i_q;
    ha_d      = ha_q;
    hb_d      = hb_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    rd_addr   = '0;
    x_we      = 1'b0;
    y_we      = 1'b0;
    x_waddr   = {count_q[TetW-1:0], j_q};
    x_wdata   = {face_key(vert_q, j_q), count_q[TetW-1:0], j_q};
    y_waddr   = o_q[FaceW-1:0];
    y_wdata   = sel_ent;
    nbr_wr    = '{we: 4'b0000, row: count_q[TetW-1:0], data: {1'b1, {TetW{1'b0}}}};

    case (state_q)
      StIdle: begin
        if (accept) begin
          last_d = s_axis_tlast_i;
          if (s_axis_tuser_i == FuncRead) begin
            state_d = StRd;
          end else begin
            if (built_q) begin
              built_d = 1'b0;
              ovf_d   = 1'b0;
            end
            count_d = eff_cnt;
            sel_d   = 1'b0;
            j_d     = '0;
            if (eff_cnt < CntW'(MaxTets)) begin
              state_d = StLoad;
            end else begin
              ovf_d   = 1'b1;
              state_d = s_axis_tlast_i ? StBinit : StIdle;
            end
          end
        end
      end
      // Four face writes, neighbor row marked boundary on the first
      StLoad: begin
        x_we = 1'b1;
        if (j_q == 2'd0) begin
          nbr_wr.we = 4'b1111;
        end
        j_d = j_q + 2'd1;
        if (j_q == 2'd3) begin
          count_d = count_q + CntW'(1);
          state_d = last_q ? StBinit : StIdle;
        end
      end
      StBinit: begin
        n_d     = {count_q, 2'b00};
        width_d = FaceCntW'(1);
        lo_d    = '0;
        state_d = StRun;
      end
      // Start of one merge run
      StRun: begin
        mid_d   = (lo_w < {1'b0, n_q}) ? lo_w[FaceCntW-1:0] : n_q;
        hi_d    = (lo_2w < {1'b0, n_q}) ? lo_2w[FaceCntW-1:0] : n_q;
        a_d     = lo_q;
        b_d     = (lo_w < {1'b0, n_q}) ? lo_w[FaceCntW-1:0] : n_q;
        o_d     = lo_q;
        state_d = StFa;
      end
      StFa: begin
        rd_addr = a_q[FaceW-1:0];
        state_d = StFa2;
      end
      StFa2: begin
        ha_d    = rdata;
        rd_addr = b_q[FaceW-1:0];
        state_d = StFb2;
      end
      StFb2: begin
        hb_d    = rdata;
        state_d = StMrg;
      end
      // Emit the smaller head to the other bank and refetch; at run end, go to next run, pass or scan
      StMrg: begin
        if (!a_ok && !b_ok) begin
          if (lo_next >= {1'b0, n_q}) begin
            sel_d   = !sel_q;
            width_d = {width_q[FaceCntW-2:0], 1'b0};
            lo_d    = '0;
            if ({width_q, 1'b0} >= {1'b0, n_q}) begin
              i_d     = '0;
              state_d = StScA;
            end else begin
              state_d = StRun;
            end
          end else begin
            lo_d    = lo_next[FaceCntW-1:0];
            state_d = StRun;
          end
        end else begin
          x_waddr  = o_q[FaceW-1:0];
          x_wdata  = sel_ent;
          x_we     = sel_q;
          y_we     = !sel_q;
          o_d      = o_q + FaceCntW'(1);
          took_a_d = take_a;
          if (take_a) begin
            a_d     = a_q + FaceCntW'(1);
            rd_addr = a_q[FaceW-1:0] + FaceW'(1);
          end else begin
            b_d     = b_q + FaceCntW'(1);
            rd_addr = b_q[FaceW-1:0] + FaceW'(1);
          end
          state_d = StCap;
        end
      end
      StCap: begin
        if (took_a_q) begin
          ha_d = rdata;
        end else begin
          hb_d = rdata;
        end
        state_d = StMrg;
      end
      // Scan sorted faces for equal neighbors
      StScA: begin
        rd_addr = i_q[FaceW-1:0];
        state_d = StScB;
      end
      StScB: begin
        if (i_q != '0 && key_eq) begin
          nbr_wr.we[prev_q[1:0]] = 1'b1;
          nbr_wr.row  = prev_q[FaceW-1:2];
          nbr_wr.data = {1'b0, rdata[FaceW-1:2]};
          cur_d       = rdata;
          state_d     = StScC;
        end else begin
          prev_d  = rdata;
          i_d     = i_q + FaceCntW'(1);
          state_d = (i_q + FaceCntW'(1) == n_q) ? StDone : StScA;
        end
      end
      StScC: begin
        nbr_wr.we[cur_q[1:0]] = 1'b1;
        nbr_wr.row  = cur_q[FaceW-1:2];
        nbr_wr.data = {1'b0, prev_q[FaceW-1:2]};
        prev_d      = cur_q;
        i_d         = i_q + FaceCntW'(1);
        state_d     = (i_q + FaceCntW'(1) == n_q) ? StDone : StScA;
      end
      StDone: begin
        if (out_free) begin
          built_d   = 1'b1;
          m_valid_d = 1'b1;
          m_user_d  = ovf_q ? StatOverflow : StatBuildDone;
          m_data_d  = {45'd0, count_q};
          state_d   = StIdle;
        end
      end
      StRd: begin
        state_d = StRd2;
      end
      // Neighbor row is on the table output
      StRd2: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          if ({1'b0, idx_q} >= rd_cnt) begin
            m_user_d = StatBadIndex;
            m_data_d = {45'd0, rd_cnt};
          end else begin
            m_user_d = StatReadOk;
            m_data_d = {1'b0, bnd_rd[3], bnd_rd[2], bnd_rd[1], bnd_rd[0],
                        nbr_rd[3], nbr_rd[2], nbr_rd[1], nbr_rd[0], rd_cnt};
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      count_q   <= '0;
      built_q   <= 1'b0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      sel_q     <= 1'b0;
      took_a_q  <= 1'b0;
      j_q       <= '0;
      n_q       <= '0;
      width_q   <= '0;
      lo_q      <= '0;
      mid_q     <= '0;
      hi_q      <= '0;
      a_q       <= '0;
      b_q       <= '0;
      o_q       <= '0;
      i_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      built_q   <= built_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      sel_q     <= sel_d;
      took_a_q  <= took_a_d;
      j_q       <= j_d;
      n_q       <= n_d;
      width_q   <= width_d;
      lo_q      <= lo_d;
      mid_q     <= mid_d;
      hi_q      <= hi_d;
      a_q       <= a_d;
      b_q       <= b_d;
      o_q       <= o_d;
      i_q       <= i_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 4; k++) begin
        vert_q[k] <= s_axis_tdata_i[k*VertInW +: VertexBits];
      end
      idx_q <= s_axis_tdata_i[4*VertInW +: TetW];
    end
    ha_q     <= ha_d;
    hb_q     <= hb_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

endmodule

/* bench/tb.sv */
// Self-checking testbench for the tetra face neighbor finder: directed and random meshes.
module tb;
  import tfnf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result transfer
  typedef struct {
    logic [1:0]  status;
    logic [10:0] count;
    logic [9:0]  nbr [4];
    logic        bound [4];
  } nbr_result_t;

  // Corner lists of the four faces, face j opposite vertex j
  localparam int FaceCorner [12] = '{1, 2, 3, 2, 3, 0, 3, 0, 1, 0, 1, 2};

  // Mesh predictor and store of expected results
  class mesh_scoreboard;
    int unsigned tets_held;
    bit          mesh_built;
    bit          dropped;
    logic [59:0] face_key [FaceSlots];
    int          face_link [FaceSlots];  // -1 marks a boundary face
    nbr_result_t pending [$];
    int          errors;

    function new();
      tets_held  = 0;
      mesh_built = 0;
      dropped    = 0;
      errors     = 0;
    endfunction

    // Sorted three-vertex key of one face
    function logic [59:0] sorted_key(logic [19:0] a, logic [19:0] b, logic [19:0] c);
      logic [19:0] t;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      if (b > c) begin
        t = b; b = c; c = t;
      end
      if (a > b) begin
        t = a; a = b; b = t;
      end
      return {a, b, c};
    endfunction

    // Sort all faces by (key, id) and link equal neighbors, later pairs win
    function void build_links();
      logic [71:0] faces [$];
      int ia;
      int ib;
      for (int i = 0; i < FaceSlots; i++) face_link[i] = -1;
      for (int i = 0; i < 4 * tets_held; i++) faces.push_back({face_key[i], 12'(i)});
      faces.sort();
      for (int i = 0; i + 1 < faces.size(); i++) begin
        if (faces[i][71:12] == faces[i+1][71:12]) begin
          ia = int'(faces[i][11:0]);
          ib = int'(faces[i+1][11:0]);
          face_link[ia] = ib >> 2;
          face_link[ib] = ia >> 2;
        end
      end
      mesh_built = 1;
    endfunction

    // Note one accepted input transfer
    function void note_transfer(logic func, logic [19:0] v [4], logic [9:0] idx, logic last);
      nbr_result_t r;
      int unsigned avail;
      r.status = StatBuildDone;
      r.count  = '0;
      for (int j = 0; j < 4; j++) begin
        r.nbr[j]   = '0;
        r.bound[j] = 1'b0;
      end
      if (func == FuncLoad) begin
        if (mesh_built) begin
          mesh_built = 0;
          dropped    = 0;
          tets_held  = 0;
        end
        if (tets_held < MaxTets) begin
          for (int j = 0; j < 4; j++)
            face_key[4*tets_held+j] = sorted_key(v[FaceCorner[3*j]], v[FaceCorner[3*j+1]],
                                                 v[FaceCorner[3*j+2]]);
          tets_held++;
        end else begin
          dropped = 1;
        end
        if (!last) return;
        build_links();
        r.status = dropped ? StatOverflow : StatBuildDone;
        r.count  = 11'(tets_held);
        pending.push_back(r);
        return;
      end
      avail   = mesh_built ? tets_held : 0;
      r.count = 11'(avail);
      if (idx >= avail) begin
        r.status = StatBadIndex;
      end else begin
        r.status = StatReadOk;
        for (int j = 0; j < 4; j++) begin
          if (face_link[4*idx+j] < 0) r.bound[j] = 1'b1;
          else r.nbr[j] = 10'(face_link[4*idx+j]);
        end
      end
      pending.push_back(r);
    endfunction

    function void field_check(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Check one accepted result transfer against the oldest expectation
    function void check_result(logic [55:0] data, logic [1:0] status);
      nbr_result_t r;
      if (pending.size() == 0) begin
        $display("%0t unexpected result: status %0d data %h", $time, status, data);
        errors++;
        return;
      end
      r = pending.pop_front();
      field_check("status", r.status, status);
      field_check("tet_count", r.count, data[10:0]);
      for (int j = 0; j < 4; j++) begin
        field_check($sformatf("nbr_%0d", j), r.nbr[j], data[11+10*j +: 10]);
        field_check($sformatf("bound_%0d", j), r.bound[j], data[51+j]);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  mesh_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int recv_hold      = 0;
  int items_sent     = 0;
  logic [19:0] vert_pool [8];

  tetra_face_neighbor_finder_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver: ready changes at the falling edge, long hold-off when requested
  always @(negedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold       <= recv_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Offer one item and wait for its transfer
  task automatic send_item(logic func, logic [19:0] v [4], logic [9:0] idx, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = func;
    s_axis_tlast_i  = last;
    s_axis_tdata_i  = {6'd0, idx, v[3], v[2], v[1], v[0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_transfer(func, v, idx, last);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  task automatic read_tet(logic [9:0] idx);
    logic [19:0] v [4];
    for (int j = 0; j < 4; j++) v[j] = 20'($urandom);
    send_item(FuncRead, v, idx, 1'($urandom));
  endtask

  task automatic load_tet(logic [19:0] v [4], logic last);
    send_item(FuncLoad, v, 10'($urandom), last);
  endtask

  // Random mesh over a small vertex pool so faces are shared often
  task automatic random_mesh(int ntets, int pool, int nreads);
    logic [19:0] v [4];
    for (int p = 0; p < 8; p++)
      vert_pool[p] = ($urandom_range(3) == 0) ? 20'(p) : 20'($urandom);
    for (int t = 0; t < ntets; t++) begin
      for (int j = 0; j < 4; j++) v[j] = vert_pool[$urandom_range(pool - 1)];
      if ($urandom_range(29) == 0) read_tet(10'($urandom_range(3)));
      load_tet(v, t == ntets - 1);
    end
    for (int r = 0; r < nreads; r++)
      read_tet(($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(ntets + 1)));
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  // Run limit
  initial begin
    #20ms;
    $display("tetra_face_neighbor_finder_top regression: fail");
    $finish;
  end

  initial begin
    logic [19:0] v [4];
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reads with no mesh, degenerate and extreme meshes
    read_tet(10'd0);
    read_tet(10'd1023);
    v = '{20'd0, 20'd0, 20'd0, 20'd0};
    load_tet(v, 1'b1);
    read_tet(10'd0);
    read_tet(10'd1);
    v = '{20'hFFFFF, 20'hFFFFE, 20'd0, 20'd1};
    load_tet(v, 1'b0);
    v = '{20'd1, 20'd7, 20'hFFFFE, 20'hFFFFF};
    load_tet(v, 1'b0);
    v = '{20'hFFFFF, 20'd0, 20'd1, 20'hFFFFE};
    read_tet(10'd0);
    load_tet(v, 1'b1);
    read_tet(10'd0);
    read_tet(10'd1);
    read_tet(10'd2);
    read_tet(10'd3);
    v = '{20'hAAAAA, 20'h55555, 20'hAAAAA, 20'h55555};
    load_tet(v, 1'b0);
    load_tet(v, 1'b1);
    read_tet(10'd0);
    read_tet(10'd1);
    read_tet(10'd1023);

    // Full mesh plus dropped loads, reads over the whole index range
    for (int t = 0; t < MaxTets + 2; t++) begin
      for (int j = 0; j < 4; j++) v[j] = 20'($urandom_range(40));
      if (t % 97 == 0) for (int j = 0; j < 4; j++) v[j] = 20'($urandom);
      load_tet(v, t == MaxTets + 1);
    end
    read_tet(10'd1023);
    read_tet(10'd0);
    // Long receiver hold-off while reads keep coming
    recv_hold = 300;
    for (int r = 0; r < 30; r++) read_tet(10'($urandom));
    // Sender pause until every result is in
    wait_drained();
    repeat (50) @(negedge clk_i);

    // Random meshes across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 81; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 81;
        end
        default: begin
          send_idle_pct = 36; recv_stall_pct = 36;
        end
      endcase
      for (int k = 0; k < 8; k++) begin
        if (k == 4) wait_drained();
        random_mesh($urandom_range(1, 16), $urandom_range(4, 8), $urandom_range(2, 8));
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (items_sent < 1500) random_mesh($urandom_range(1, 20), $urandom_range(4, 8), 6);

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tetra_face_neighbor_finder_top regression: pass");
    end else begin
      $display("tetra_face_neighbor_finder_top regression: fail");
    end
    $finish;
  end
endmodule

/* tetra_face_neighbor_finder_top.f */
rtl/core/tfnf_pkg.sv
rtl/core/tfnf_ram.sv
rtl/core/tfnf_nbr_table.sv
rtl/core/tetra_face_neighbor_finder_top.sv
bench/tb.sv
